/* rtl/core/setq_pkg.sv */
`default_nettype none

package setq_pkg;

    // Default sizes of the queue
    localparam int DEPTH_DEF     = 64;
    localparam int TIME_BITS_DEF = 32;

    // Fixed payload widths on the channels
    localparam int HANDLE_W  = 16;
    localparam int TIME_IN_W = 32;
    localparam int MODE_W    = 2;
    localparam int STATUS_W  = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD  = 2'd0,
        MODE_DEL  = 2'd1,
        MODE_ADJ  = 2'd2,
        MODE_TICK = 2'd3
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_MISSING = 2'd2,
        ST_DUP     = 2'd3
    } status_t;

    // Result of the shared entry compare unit
    typedef struct packed {
        logic le;   // entry expiry not later than the key time
        logic hit;  // entry handle equals the key handle
    } cmp_res_t;

endpackage

`default_nettype wire

/* rtl/core/setq_if.sv */
`default_nettype none

interface setq_cmd_if;
    import setq_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [MODE_W-1:0]    mode;
    logic [HANDLE_W-1:0]  handle;
    logic [TIME_IN_W-1:0] expire_time;
    logic [TIME_IN_W-1:0] current_time;

    modport source (output valid, mode, handle, expire_time, current_time, input ready);
    modport sink   (input valid, mode, handle, expire_time, current_time, output ready);
endinterface

interface setq_rsp_if;
    import setq_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                expired_valid;
    logic [HANDLE_W-1:0] expired_handle;
    logic                last;

    modport source (output valid, status, expired_valid, expired_handle, last, input ready);
    modport sink   (input valid, status, expired_valid, expired_handle, last, output ready);
endinterface

`default_nettype wire

/* rtl/core/setq_store.sv */
`default_nettype none

module setq_store #(
    parameter int DEPTH     = setq_pkg::DEPTH_DEF,
    parameter int TIME_BITS = setq_pkg::TIME_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
    input  wire logic [TIME_BITS-1:0]          wr_expiry,
    input  wire logic [setq_pkg::HANDLE_W-1:0] wr_handle,
    input  wire logic                          rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]      rd_addr,
    output      logic [TIME_BITS-1:0]          rd_expiry,
    output      logic [setq_pkg::HANDLE_W-1:0] rd_handle
);
    import setq_pkg::*;

    logic [TIME_BITS-1:0] expiry_mem [DEPTH];
    logic [HANDLE_W-1:0]  handle_mem [DEPTH];
    logic [TIME_BITS-1:0] rd_expiry_reg;
    logic [HANDLE_W-1:0]  rd_handle_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            expiry_mem[wr_addr] <= wr_expiry;
            handle_mem[wr_addr] <= wr_handle;
        end
        // hold read data until the next read
        if (rd_en)
        begin
            rd_expiry_reg <= expiry_mem[rd_addr];
            rd_handle_reg <= handle_mem[rd_addr];
        end
    end

    assign rd_expiry = rd_expiry_reg;
    assign rd_handle = rd_handle_reg;

endmodule

`default_nettype wire

/* rtl/core/setq_cmp.sv */
`default_nettype none

module setq_cmp #(
    parameter int TIME_BITS = setq_pkg::TIME_BITS_DEF
) (
    input  wire logic [TIME_BITS-1:0]          entry_expiry,
    input  wire logic [setq_pkg::HANDLE_W-1:0] entry_handle,
    input  wire logic [TIME_BITS-1:0]          key_time,
    input  wire logic [setq_pkg::HANDLE_W-1:0] key_handle,
    output      setq_pkg::cmp_res_t            res
);
    import setq_pkg::*;

    assign res.le  = (entry_expiry <= key_time);
    assign res.hit = (entry_handle == key_handle);

endmodule

`default_nettype wire

/* rtl/core/sorted_expiry_timer_queue_unit.sv */
// Sorted expiry timer queue: up to DEPTH (handle, expiry) timers kept in
// ascending expiry order, equal expiries in arrival order.
// Channels: cmd (sink) takes one transaction per command: mode add, delete,
// adjust or tick, with handle, expire_time and current_time. rsp (source)
// returns results: status, expired_valid, expired_handle and last. Add, delete
// and adjust return one result; a tick returns one result per expired timer
// (last set on the final one), or a single empty result if nothing expired.
// Timing: cmd.ready is high only while the sequencer is idle. Add, delete and
// adjust do a search walk over the N live entries, then shift entries in the
// ring memory (up to N) one at a time. A tick examines entries from the head.
// The single read port of the entry memory paces this: the search walk reads
// one entry per cycle, a shift is a read followed by a write, and a tick reads
// and then checks each entry.
// Results go through a one-deep output register, so a new command is taken
// while the last result still waits. A stalled rsp holds the sequencer at its
// next result; nothing is dropped.
// Reset: asynchronous, active low; empties the queue (count and ring head to
// zero). The entry memory is not cleared: only live entries are ever read.
`default_nettype none

module sorted_expiry_timer_queue_unit #(
    parameter int DEPTH     = setq_pkg::DEPTH_DEF,
    parameter int TIME_BITS = setq_pkg::TIME_BITS_DEF
) (
    input wire logic  clk,
    input wire logic  rst_n,
    setq_cmd_if.sink  cmd,
    setq_rsp_if.source rsp
);
    import setq_pkg::*;

    localparam int AW = $clog2(DEPTH);     // physical memory index
    localparam int CW = $clog2(DEPTH + 1); // logical index / count
    localparam int SW = AW + 1;            // head plus logical index

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_MOVE_RD,
        S_MOVE_WR,
        S_PLACE,
        S_REPLY,
        S_TICK_RD,
        S_TICK_CHK,
        S_TICK_END
    } state_t;

    state_t               state_reg, state_next;
    logic [AW-1:0]        head_reg, head_next;
    logic [CW-1:0]        count_reg, count_next;
    mode_t                mode_reg, mode_next;
    logic [HANDLE_W-1:0]  key_handle_reg, key_handle_next;
    logic [TIME_BITS-1:0] key_time_reg, key_time_next;

    // search walk
    logic [CW-1:0]        idx_reg, idx_next;
    logic                 cmp_valid_reg, cmp_valid_next;
    logic [CW-1:0]        cmp_idx_reg, cmp_idx_next;
    logic                 found_reg, found_next;
    logic [CW-1:0]        found_pos_reg, found_pos_next;
    logic                 gt_seen_reg, gt_seen_next;
    logic [CW-1:0]        gt_pos_reg, gt_pos_next;

    // shift walk
    logic                 up_reg, up_next;
    logic                 place_reg, place_next;
    logic [CW-1:0]        mv_idx_reg, mv_idx_next;
    logic [CW-1:0]        mv_end_reg, mv_end_next;
    status_t              status_reg, status_next;

    // tick: expired handle held back until we know whether it is the last
    logic                 pend_valid_reg, pend_valid_next;
    logic [HANDLE_W-1:0]  pend_handle_reg, pend_handle_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    status_t              out_status_reg, out_status_next;
    logic                 out_ev_reg, out_ev_next;
    logic [HANDLE_W-1:0]  out_handle_reg, out_handle_next;
    logic                 out_last_reg, out_last_next;

    // memory side
    logic                 rd_en;
    logic [CW-1:0]        rd_log;
    logic [AW-1:0]        rd_addr;
    logic [TIME_BITS-1:0] rd_expiry;
    logic [HANDLE_W-1:0]  rd_handle;
    logic                 wr_en;
    logic [CW-1:0]        wr_log;
    logic [AW-1:0]        wr_addr;
    logic [TIME_BITS-1:0] wr_expiry;
    logic [HANDLE_W-1:0]  wr_handle;

    cmp_res_t             cmp_res;
    logic                 can_emit;
    logic [CW-1:0]        q_adj;
    logic                 mv_more;

    // Map a logical queue position onto the ring memory.
    function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] head,
                                                input logic [CW-1:0] pos);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(pos);
        if (sum >= SW'(DEPTH))
        begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    assign rd_addr = ring_addr(head_reg, rd_log);
    assign wr_addr = ring_addr(head_reg, wr_log);

    setq_store #(
        .DEPTH     (DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_expiry (wr_expiry),
        .wr_handle (wr_handle),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .rd_expiry (rd_expiry),
        .rd_handle (rd_handle)
    );

    // One compare unit serves the search walk and the tick scan.
    setq_cmp #(
        .TIME_BITS (TIME_BITS)
    ) u_cmp (
        .entry_expiry (rd_expiry),
        .entry_handle (rd_handle),
        .key_time     (key_time_reg),
        .key_handle   (key_handle_reg),
        .res          (cmp_res)
    );

    // The result slot is free when empty or being taken this cycle.
    assign can_emit = !out_valid_reg || rsp.ready;

    // Insert position for adjust, counted after the entry is taken out: the
    // old entry lies before the first later expiry exactly when its own expiry
    // is not later than the new one.
    assign q_adj = (found_reg && (found_pos_reg < gt_pos_reg)) ?
                   (gt_pos_reg - CW'(1)) : gt_pos_reg;

    assign mv_more = up_reg ? (mv_idx_reg > mv_end_reg) : (mv_idx_reg < mv_end_reg);

    always_comb
    begin
        state_next       = state_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        mode_next        = mode_reg;
        key_handle_next  = key_handle_reg;
        key_time_next    = key_time_reg;
        idx_next         = idx_reg;
        cmp_valid_next   = cmp_valid_reg;
        cmp_idx_next     = cmp_idx_reg;
        found_next       = found_reg;
        found_pos_next   = found_pos_reg;
        gt_seen_next     = gt_seen_reg;
        gt_pos_next      = gt_pos_reg;
        up_next          = up_reg;
        place_next       = place_reg;
        mv_idx_next      = mv_idx_reg;
        mv_end_next      = mv_end_reg;
        status_next      = status_reg;
        pend_valid_next  = pend_valid_reg;
        pend_handle_next = pend_handle_reg;
        out_valid_next   = out_valid_reg;
        out_status_next  = out_status_reg;
        out_ev_next      = out_ev_reg;
        out_handle_next  = out_handle_reg;
        out_last_next    = out_last_reg;

        rd_en     = 1'b0;
        rd_log    = '0;
        wr_en     = 1'b0;
        wr_log    = '0;
        wr_expiry = key_time_reg;
        wr_handle = key_handle_reg;

        // drop the held result once the receiver takes it
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    mode_next       = mode_t'(cmd.mode);
                    key_handle_next = cmd.handle;
                    if (mode_t'(cmd.mode) == MODE_TICK)
                    begin
                        key_time_next = TIME_BITS'(cmd.current_time);
                        state_next    = S_TICK_RD;
                    end
                    else
                    begin
                        key_time_next  = TIME_BITS'(cmd.expire_time);
                        idx_next       = '0;
                        cmp_valid_next = 1'b0;
                        found_next     = 1'b0;
                        gt_seen_next   = 1'b0;
                        gt_pos_next    = count_reg;
                        state_next     = S_SEARCH;
                    end
                end
            end

            S_SEARCH:
            begin
                // issue the next read while comparing the previous one
                if (idx_reg < count_reg)
                begin
                    rd_en          = 1'b1;
                    rd_log         = idx_reg;
                    idx_next       = idx_reg + CW'(1);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = idx_reg;
                end
                else
                begin
                    cmp_valid_next = 1'b0;
                end
                if (cmp_valid_reg)
                begin
                    if (cmp_res.hit && !found_reg)
                    begin
                        found_next     = 1'b1;
                        found_pos_next = cmp_idx_reg;
                    end
                    if (!cmp_res.le && !gt_seen_reg)
                    begin
                        gt_seen_next = 1'b1;
                        gt_pos_next  = cmp_idx_reg;
                    end
                end
                if (idx_reg >= count_reg && !cmp_valid_reg)
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                status_next = ST_OK;
                case (mode_reg)
                    MODE_ADD:
                    begin
                        if (found_reg)
                        begin
                            status_next = ST_DUP;
                            state_next  = S_REPLY;
                        end
                        else if (count_reg == CW'(DEPTH))
                        begin
                            status_next = ST_FULL;
                            state_next  = S_REPLY;
                        end
                        else
                        begin
                            // open a gap at the insert position, top down
                            up_next     = 1'b1;
                            place_next  = 1'b1;
                            mv_idx_next = count_reg;
                            mv_end_next = gt_pos_reg;
                            state_next  = S_MOVE_RD;
                        end
                    end
                    MODE_DEL:
                    begin
                        if (!found_reg)
                        begin
                            status_next = ST_MISSING;
                            state_next  = S_REPLY;
                        end
                        else
                        begin
                            // close the gap, bottom up
                            up_next     = 1'b0;
                            place_next  = 1'b0;
                            mv_idx_next = found_pos_reg;
                            mv_end_next = count_reg - CW'(1);
                            state_next  = S_MOVE_RD;
                        end
                    end
                    MODE_ADJ:
                    begin
                        if (!found_reg)
                        begin
                            status_next = ST_MISSING;
                            state_next  = S_REPLY;
                        end
                        else
                        begin
                            // shift only the span between old and new slot
                            up_next     = (q_adj < found_pos_reg);
                            place_next  = 1'b1;
                            mv_idx_next = found_pos_reg;
                            mv_end_next = q_adj;
                            state_next  = S_MOVE_RD;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_MOVE_RD:
            begin
                if (mv_more)
                begin
                    rd_en      = 1'b1;
                    rd_log     = up_reg ? (mv_idx_reg - CW'(1)) : (mv_idx_reg + CW'(1));
                    state_next = S_MOVE_WR;
                end
                else if (place_reg)
                begin
                    state_next = S_PLACE;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_REPLY;
                end
            end

            S_MOVE_WR:
            begin
                wr_en       = 1'b1;
                wr_log      = mv_idx_reg;
                wr_expiry   = rd_expiry;
                wr_handle   = rd_handle;
                mv_idx_next = up_reg ? (mv_idx_reg - CW'(1)) : (mv_idx_reg + CW'(1));
                state_next  = S_MOVE_RD;
            end

            S_PLACE:
            begin
                wr_en  = 1'b1;
                wr_log = mv_end_reg;
                if (mode_reg == MODE_ADD)
                begin
                    count_next = count_reg + CW'(1);
                end
                state_next = S_REPLY;
            end

            S_REPLY:
            begin
                if (can_emit)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_ev_next     = 1'b0;
                    out_handle_next = '0;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end

            S_TICK_RD:
            begin
                if (count_reg == '0)
                begin
                    state_next = S_TICK_END;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_log     = '0;
                    state_next = S_TICK_CHK;
                end
            end

            S_TICK_CHK:
            begin
                if (cmp_res.le)
                begin
                    if (!pend_valid_reg || can_emit)
                    begin
                        // another one expired, so the held one is not last
                        if (pend_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = ST_OK;
                            out_ev_next     = 1'b1;
                            out_handle_next = pend_handle_reg;
                            out_last_next   = 1'b0;
                        end
                        pend_valid_next  = 1'b1;
                        pend_handle_next = rd_handle;
                        head_next        = (head_reg == AW'(DEPTH - 1)) ?
                                           '0 : (head_reg + AW'(1));
                        count_next       = count_reg - CW'(1);
                        state_next       = S_TICK_RD;
                    end
                end
                else
                begin
                    state_next = S_TICK_END;
                end
            end

            S_TICK_END:
            begin
                if (can_emit)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_ev_next     = pend_valid_reg;
                    out_handle_next = pend_valid_reg ? pend_handle_reg : '0;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            head_reg        <= '0;
            count_reg       <= '0;
            mode_reg        <= MODE_ADD;
            key_handle_reg  <= '0;
            key_time_reg    <= '0;
            idx_reg         <= '0;
            cmp_valid_reg   <= 1'b0;
            cmp_idx_reg     <= '0;
            found_reg       <= 1'b0;
            found_pos_reg   <= '0;
            gt_seen_reg     <= 1'b0;
            gt_pos_reg      <= '0;
            up_reg          <= 1'b0;
            place_reg       <= 1'b0;
            mv_idx_reg      <= '0;
            mv_end_reg      <= '0;
            status_reg      <= ST_OK;
            pend_valid_reg  <= 1'b0;
            pend_handle_reg <= '0;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= ST_OK;
            out_ev_reg      <= 1'b0;
            out_handle_reg  <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            head_reg        <= head_next;
            count_reg       <= count_next;
            mode_reg        <= mode_next;
            key_handle_reg  <= key_handle_next;
            key_time_reg    <= key_time_next;
            idx_reg         <= idx_next;
            cmp_valid_reg   <= cmp_valid_next;
            cmp_idx_reg     <= cmp_idx_next;
            found_reg       <= found_next;
            found_pos_reg   <= found_pos_next;
            gt_seen_reg     <= gt_seen_next;
            gt_pos_reg      <= gt_pos_next;
            up_reg          <= up_next;
            place_reg       <= place_next;
            mv_idx_reg      <= mv_idx_next;
            mv_end_reg      <= mv_end_next;
            status_reg      <= status_next;
            pend_valid_reg  <= pend_valid_next;
            pend_handle_reg <= pend_handle_next;
            out_valid_reg   <= out_valid_next;
            out_status_reg  <= out_status_next;
            out_ev_reg      <= out_ev_next;
            out_handle_reg  <= out_handle_next;
            out_last_reg    <= out_last_next;
        end
    end

    assign cmd.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.expired_valid  = out_ev_reg;
    assign rsp.expired_handle = out_handle_reg;
    assign rsp.last           = out_last_reg;

    // Queue never holds more than DEPTH entries.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    // An add only places an entry when there is room for it.
    a_place_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PLACE && mode_reg == MODE_ADD) |-> count_reg < CW'(DEPTH))
        else $error("insert into a full queue");

    // Expired handles are always reported with status ok.
    a_expired_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_ev_reg) |-> (out_status_reg == ST_OK))
        else $error("expired result with a failing status");

    // A held expired handle only lives inside the tick scan.
    a_pend_scope: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> (state_reg == S_TICK_RD || state_reg == S_TICK_CHK ||
                            state_reg == S_TICK_END))
        else $error("held expired handle outside tick");

endmodule

`default_nettype wire

/* tb/sorted_expiry_timer_queue_unit_tb.sv */
`timescale 1ns / 1ps

module sorted_expiry_timer_queue_unit_tb;
    import setq_pkg::*;

    localparam int TQ_DEPTH     = DEPTH_DEF;
    localparam int POOL_SIZE    = 24;
    localparam int N_DIR        = 25;
    localparam int RANDOM_ITEMS = 250;
    // The limit covers the longest single command, with plenty of margin
    // on top of the longest sender gap and receiver stall.
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 3 * TQ_DEPTH + 200;

    // One result transaction as seen on the rsp channel.
    typedef struct packed {
        status_t         status;
        logic            expired_valid;
        logic [HANDLE_W-1:0] expired_handle;
        logic            last;
    } timer_result_t;

    // One live timer in the shadow queue.
    typedef struct packed {
        logic [HANDLE_W-1:0]  handle;
        logic [TIME_IN_W-1:0] expiry;
    } timer_entry_t;

    // One row of the directed table. Rows with pinned set carry their result
    // by hand; all pinned results are single, non-expiry results with last set.
    typedef struct {
        mode_t                mode;
        logic [HANDLE_W-1:0]  handle;
        logic [TIME_IN_W-1:0] expire_time;
        logic [TIME_IN_W-1:0] current_time;
        bit                   pinned;
        status_t              pin_status;
    } cmd_row_t;

    logic clk;
    logic rst_n;

    setq_cmd_if cmd_bus ();
    setq_rsp_if rsp_bus ();

    sorted_expiry_timer_queue_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    // Shadow state of the block and the results it still owes us.
    timer_entry_t  shadow_q[$];
    timer_result_t fresh_results[$];
    timer_result_t expected_results[$];

    logic [HANDLE_W-1:0]  handle_pool [POOL_SIZE];
    logic [TIME_IN_W-1:0] clock_now;
    bit                   no_idle;
    int                   err_count;
    int                   idle_cycles;

    function automatic timer_result_t timer_result(status_t s, logic v,
                                                   logic [HANDLE_W-1:0] h, logic l);
        timer_result_t r;
        r.status         = s;
        r.expired_valid  = v;
        r.expired_handle = h;
        r.last           = l;
        return r;
    endfunction

    function automatic cmd_row_t mk_row(mode_t m, logic [HANDLE_W-1:0] h,
                                        logic [TIME_IN_W-1:0] te,
                                        logic [TIME_IN_W-1:0] tc,
                                        bit pin, status_t ps);
        cmd_row_t r;
        r.mode         = m;
        r.handle       = h;
        r.expire_time  = te;
        r.current_time = tc;
        r.pinned       = pin;
        r.pin_status   = ps;
        return r;
    endfunction

    function automatic int timer_find(logic [HANDLE_W-1:0] h);
        for (int i = 0; i < shadow_q.size(); i++)
            if (shadow_q[i].handle == h)
                return i;
        return -1;
    endfunction

    // Place a timer after every entry whose expiry is not later than its own,
    // so equal expiries stay in arrival order.
    function automatic void timer_insert(logic [HANDLE_W-1:0] h, logic [TIME_IN_W-1:0] t);
        timer_entry_t e;
        int           pos;
        e.handle = h;
        e.expiry = t;
        pos = 0;
        while (pos < shadow_q.size() && shadow_q[pos].expiry <= t)
            pos++;
        shadow_q.insert(pos, e);
    endfunction

    // Apply one command to the shadow queue and collect the results it owes
    // into fresh_results.
    function automatic void predict_timer_cmd(mode_t m, logic [HANDLE_W-1:0] h,
                                              logic [TIME_IN_W-1:0] te,
                                              logic [TIME_IN_W-1:0] tc);
        int           pos;
        bit           more;
        timer_entry_t e;
        fresh_results.delete();
        pos = timer_find(h);
        case (m)
            MODE_ADD:
            begin
                // The duplicate check wins over the full check.
                if (pos >= 0)
                    fresh_results.push_back(timer_result(ST_DUP, 1'b0, '0, 1'b1));
                else if (shadow_q.size() >= TQ_DEPTH)
                    fresh_results.push_back(timer_result(ST_FULL, 1'b0, '0, 1'b1));
                else
                begin
                    timer_insert(h, te);
                    fresh_results.push_back(timer_result(ST_OK, 1'b0, '0, 1'b1));
                end
            end
            MODE_DEL, MODE_ADJ:
            begin
                if (pos < 0)
                    fresh_results.push_back(timer_result(ST_MISSING, 1'b0, '0, 1'b1));
                else
                begin
                    shadow_q.delete(pos);
                    if (m == MODE_ADJ)
                        timer_insert(h, te);
                    fresh_results.push_back(timer_result(ST_OK, 1'b0, '0, 1'b1));
                end
            end
            default:
            begin
                // Emit every timer at or before the current time, head first.
                while (shadow_q.size() > 0 && shadow_q[0].expiry <= tc)
                begin
                    e = shadow_q.pop_front();
                    more = (shadow_q.size() > 0 && shadow_q[0].expiry <= tc);
                    fresh_results.push_back(timer_result(ST_OK, 1'b1, e.handle, !more));
                end
                if (fresh_results.size() == 0)
                    fresh_results.push_back(timer_result(ST_OK, 1'b0, '0, 1'b1));
            end
        endcase
    endfunction

    // Gap length for either side: mostly none, often short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Drive one command transaction, hold it until accepted, then predict its
    // results at the accepting edge. A pinned row replaces the prediction
    // with its hand-written result but still advances the shadow queue.
    task automatic issue_cmd(mode_t m, logic [HANDLE_W-1:0] h,
                             logic [TIME_IN_W-1:0] te, logic [TIME_IN_W-1:0] tc,
                             bit pin, status_t ps);
        int gap;
        cmd_bus.valid        <= 1'b1;
        cmd_bus.mode         <= m;
        cmd_bus.handle       <= h;
        cmd_bus.expire_time  <= te;
        cmd_bus.current_time <= tc;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        predict_timer_cmd(m, h, te, tc);
        if (pin)
            expected_results.push_back(timer_result(ps, 1'b0, '0, 1'b1));
        else
            foreach (fresh_results[i])
                expected_results.push_back(fresh_results[i]);
        gap = pick_gap();
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [HANDLE_W-1:0] fresh_handle();
        logic [HANDLE_W-1:0] h;
        h = HANDLE_W'($urandom);
        while (timer_find(h) >= 0)
            h = HANDLE_W'($urandom);
        return h;
    endfunction

    // Mostly well-formed traffic on a small handle pool, so deletes and
    // adjusts usually hit; the rest is random handles and wild times.
    task automatic issue_random_cmd();
        int                   sel;
        mode_t                m;
        logic [HANDLE_W-1:0]  h;
        logic [TIME_IN_W-1:0] te;
        logic [TIME_IN_W-1:0] tc;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            m = MODE_ADD;
        else if (sel < 55)
            m = MODE_DEL;
        else if (sel < 75)
            m = MODE_ADJ;
        else
            m = MODE_TICK;

        if ($urandom_range(0, 9) == 0)
            h = HANDLE_W'($urandom);
        else if (m != MODE_ADD && shadow_q.size() > 0 && $urandom_range(0, 9) < 7)
            h = shadow_q[$urandom_range(0, shadow_q.size() - 1)].handle;
        else
            h = handle_pool[$urandom_range(0, POOL_SIZE - 1)];

        if ($urandom_range(0, 19) == 0)
            te = $urandom;
        else
            te = clock_now + $urandom_range(0, 50);

        tc = $urandom;
        if (m == MODE_TICK)
        begin
            clock_now = clock_now + $urandom_range(0, 25);
            if ($urandom_range(0, 29) != 0)
                tc = clock_now;
        end
        issue_cmd(m, h, te, tc, 1'b0, ST_OK);
    endtask

    // Fill the queue to the brim, hit the full and duplicate paths, churn a
    // little while full, then tick well past every expiry set here.
    task automatic fill_and_drain();
        logic [HANDLE_W-1:0] h;
        while (shadow_q.size() < TQ_DEPTH)
            issue_cmd(MODE_ADD, fresh_handle(), clock_now + $urandom_range(1, 40),
                      $urandom, 1'b0, ST_OK);
        issue_cmd(MODE_ADD, fresh_handle(), $urandom, $urandom, 1'b1, ST_FULL);
        h = shadow_q[$urandom_range(0, TQ_DEPTH - 1)].handle;
        issue_cmd(MODE_ADD, h, $urandom, $urandom, 1'b1, ST_DUP);
        h = shadow_q[$urandom_range(0, TQ_DEPTH - 1)].handle;
        issue_cmd(MODE_ADJ, h, clock_now + $urandom_range(0, 40), $urandom, 1'b0, ST_OK);
        h = shadow_q[$urandom_range(0, TQ_DEPTH - 1)].handle;
        issue_cmd(MODE_DEL, h, $urandom, $urandom, 1'b0, ST_OK);
        issue_cmd(MODE_ADD, fresh_handle(), clock_now + $urandom_range(0, 40),
                  $urandom, 1'b0, ST_OK);
        h = shadow_q[$urandom_range(0, TQ_DEPTH - 1)].handle;
        issue_cmd(MODE_ADJ, h, clock_now, $urandom, 1'b0, ST_OK);
        clock_now = clock_now + 100;
        issue_cmd(MODE_TICK, HANDLE_W'($urandom), $urandom, clock_now, 1'b0, ST_OK);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver side: alternate runs of ready with stalls of random length.
    initial
    begin
        rsp_bus.ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            int stall;
            stall = pick_gap();
            if (stall > 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // Compare every accepted result with the oldest one still owed.
    always @(posedge clk)
    begin : rsp_check
        timer_result_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (expected_results.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected result, expected none, got %0d %0b %h %0b",
                         $time, rsp_bus.status, rsp_bus.expired_valid,
                         rsp_bus.expired_handle, rsp_bus.last);
            end
            else
            begin
                want = expected_results.pop_front();
                if (rsp_bus.status !== want.status)
                begin
                    err_count++;
                    $display("%0t: status mismatch, expected %0d, got %0d",
                             $time, want.status, rsp_bus.status);
                end
                if (rsp_bus.expired_valid !== want.expired_valid)
                begin
                    err_count++;
                    $display("%0t: expired_valid mismatch, expected %0b, got %0b",
                             $time, want.expired_valid, rsp_bus.expired_valid);
                end
                if (rsp_bus.expired_handle !== want.expired_handle)
                begin
                    err_count++;
                    $display("%0t: expired_handle mismatch, expected %h, got %h",
                             $time, want.expired_handle, rsp_bus.expired_handle);
                end
                if (rsp_bus.last !== want.last)
                begin
                    err_count++;
                    $display("%0t: last mismatch, expected %0b, got %0b",
                             $time, want.last, rsp_bus.last);
                end
            end
        end
    end

    // Watchdog: give up when neither channel moves a transaction for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_bus.valid && cmd_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        cmd_row_t dir_rows [N_DIR];

        cmd_bus.valid        = 1'b0;
        cmd_bus.mode         = MODE_TICK;
        cmd_bus.handle       = '0;
        cmd_bus.expire_time  = '0;
        cmd_bus.current_time = '0;
        rst_n       = 1'b0;
        no_idle     = 1'b0;
        err_count   = 0;
        idle_cycles = 0;
        clock_now   = $urandom_range(0, 1000000);
        foreach (handle_pool[i])
            handle_pool[i] = HANDLE_W'($urandom);

        // Directed table: empty queue, missing handles, extremes of handle
        // and time, ties at equal expiry, adjust both earlier and later,
        // ticks that expire nothing, one entry and several entries.
        dir_rows[0]  = mk_row(MODE_TICK, 16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ST_OK);
        dir_rows[1]  = mk_row(MODE_DEL,  16'h1234, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1,
                              ST_MISSING);
        dir_rows[2]  = mk_row(MODE_ADJ,  16'h1234, 32'h0000_000A, 32'h0000_0000, 1'b1,
                              ST_MISSING);
        dir_rows[3]  = mk_row(MODE_ADD,  16'h0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, ST_OK);
        dir_rows[4]  = mk_row(MODE_ADD,  16'hFFFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, ST_OK);
        dir_rows[5]  = mk_row(MODE_ADD,  16'h0000, 32'h0000_0005, 32'h0000_0000, 1'b1, ST_DUP);
        dir_rows[6]  = mk_row(MODE_ADD,  16'h5555, 32'd100,       32'h0000_0000, 1'b0, ST_OK);
        dir_rows[7]  = mk_row(MODE_ADD,  16'hAAAA, 32'd100,       32'h0000_0000, 1'b0, ST_OK);
        dir_rows[8]  = mk_row(MODE_ADD,  16'h0101, 32'd50,        32'h0000_0000, 1'b0, ST_OK);
        dir_rows[9]  = mk_row(MODE_ADJ,  16'h0101, 32'd200,       32'h0000_0000, 1'b0, ST_OK);
        dir_rows[10] = mk_row(MODE_ADJ,  16'hAAAA, 32'd1,         32'h0000_0000, 1'b0, ST_OK);
        dir_rows[11] = mk_row(MODE_TICK, 16'h0000, 32'h0000_0000, 32'd0,         1'b0, ST_OK);
        dir_rows[12] = mk_row(MODE_TICK, 16'h0000, 32'h0000_0000, 32'd99,        1'b0, ST_OK);
        dir_rows[13] = mk_row(MODE_TICK, 16'h0000, 32'h0000_0000, 32'd150,       1'b0, ST_OK);
        dir_rows[14] = mk_row(MODE_DEL,  16'hFFFF, 32'h0000_0000, 32'h0000_0000, 1'b1, ST_OK);
        dir_rows[15] = mk_row(MODE_TICK, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, ST_OK);
        dir_rows[16] = mk_row(MODE_TICK, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, ST_OK);
        dir_rows[17] = mk_row(MODE_ADD,  16'h1111, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, ST_OK);
        dir_rows[18] = mk_row(MODE_ADD,  16'h2222, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, ST_OK);
        dir_rows[19] = mk_row(MODE_ADD,  16'h3333, 32'd7,         32'h0000_0000, 1'b0, ST_OK);
        dir_rows[20] = mk_row(MODE_ADD,  16'h4444, 32'd7,         32'h0000_0000, 1'b0, ST_OK);
        // Re-placing at the same expiry moves the timer behind its equals.
        dir_rows[21] = mk_row(MODE_ADJ,  16'h3333, 32'd7,         32'h0000_0000, 1'b0, ST_OK);
        dir_rows[22] = mk_row(MODE_TICK, 16'h0000, 32'h0000_0000, 32'd7,         1'b0, ST_OK);
        dir_rows[23] = mk_row(MODE_TICK, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFE, 1'b1, ST_OK);
        dir_rows[24] = mk_row(MODE_TICK, 16'h0000, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, ST_OK);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            issue_cmd(dir_rows[i].mode, dir_rows[i].handle, dir_rows[i].expire_time,
                      dir_rows[i].current_time, dir_rows[i].pinned, dir_rows[i].pin_status);

        // Random traffic, broken up by three fill-and-drain passes; the middle
        // pass and a stretch after it run with no idling on either side.
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == 80 || k == 160 || k == 240)
            begin
                no_idle = (k == 160);
                fill_and_drain();
            end
            if (k == 200)
                no_idle = 1'b0;
            issue_random_cmd();
        end
        no_idle = 1'b0;
        cmd_bus.valid <= 1'b0;

        // Let the owed results come back, then watch for stray ones.
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
